FILE: sv/fbd_pkg.sv
// ----------------------------------------------------------------------------
// fbd_pkg: shared definitions for the controller frame button decoder
// Frame layout constants, button map and the types passed between modules.
// ----------------------------------------------------------------------------
package fbd_pkg;

  localparam int WinDepth  = 7;
  localparam int LowKeys   = 7;
  localparam int HighKeys  = 5;
  localparam int KeyCount  = LowKeys + HighKeys;
  localparam int KeyIdxW   = $clog2(KeyCount);
  localparam int FillW     = $clog2(WinDepth + 1);

  localparam logic [7:0] SyncByte  = 8'h80;
  localparam logic [6:0] FirstCode = 7'h41;  // 'A'; 'H' follows 'G' directly

  // Result of checking one candidate frame.
  typedef struct packed {
    logic                hit;
    logic [KeyCount-1:0] keys;
  } frame_chk_t;

  // Emitter status seen by the top level.
  typedef struct packed {
    logic busy;  // key mask holds codes not yet sent
    logic free;  // key mask is empty after this cycle's send
  } emit_stat_t;

endpackage

FILE: sv/fbd_window.sv
// ----------------------------------------------------------------------------
// fbd_window: byte window and frame check
// Holds the seven previous bytes and checks sync byte and checksum of the
// candidate frame formed with the current byte.
// ----------------------------------------------------------------------------
module fbd_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output fbd_pkg::frame_chk_t chk
);

  logic [7:0]                win [fbd_pkg::WinDepth];
  logic [fbd_pkg::FillW-1:0] fill_count;
  logic                      full;
  logic [6:0]                sum;

  assign full = (fill_count == fbd_pkg::FillW'(fbd_pkg::WinDepth));

  // Bytes 1 to 6 of the frame are window entries 1 to 6.
  assign sum = win[1][6:0] + win[2][6:0] + win[3][6:0]
             + win[4][6:0] + win[5][6:0] + win[6][6:0];

  always_comb begin
    chk.hit  = full && (win[0] == fbd_pkg::SyncByte) && (rx_byte == {1'b0, sum});
    chk.keys = {win[1][fbd_pkg::HighKeys-1:0], win[2][fbd_pkg::LowKeys-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (take) begin
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end else if (chk.hit) begin
        fill_count <= '0;
      end
    end
  end

  // Entries at or above the fill count are never read before written.
  always_ff @(posedge clk) begin
    if (take) begin
      if (!full) begin
        win[fill_count[$clog2(fbd_pkg::WinDepth)-1:0]] <= rx_byte;
      end else if (!chk.hit) begin
        for (int i = 0; i < fbd_pkg::WinDepth - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[fbd_pkg::WinDepth-1] <= rx_byte;
      end
    end
  end

endmodule

FILE: sv/fbd_emitter.sv
// ----------------------------------------------------------------------------
// fbd_emitter: button code sender
// Holds the pressed-button mask of a frame and sends one ASCII code per cycle
// unless the output stalls, lowest button first, through an output register.
// ----------------------------------------------------------------------------
module fbd_emitter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  fbd_pkg::frame_chk_t  chk,
  output fbd_pkg::emit_stat_t  stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           key_code,
  output logic                 last_key
);

  logic [fbd_pkg::KeyCount-1:0] key_mask;
  logic [fbd_pkg::KeyCount-1:0] key_mask_next;
  logic [fbd_pkg::KeyCount-1:0] mask_rest;
  logic [fbd_pkg::KeyIdxW-1:0]  low_idx;
  logic                         send;

  always_comb begin
    low_idx = '0;
    for (int i = fbd_pkg::KeyCount - 1; i >= 0; i--) begin
      if (key_mask[i]) begin
        low_idx = fbd_pkg::KeyIdxW'(i);
      end
    end
  end

  assign send      = (key_mask != '0) && (!out_valid || !out_stall);
  assign mask_rest = send ? (key_mask & (key_mask - 1'b1)) : key_mask;

  assign stat.busy = (key_mask != '0);
  assign stat.free = (mask_rest == '0);

  always_comb begin
    key_mask_next = mask_rest;
    if (load) begin
      key_mask_next = chk.hit ? chk.keys : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      key_mask <= key_mask_next;
      if (send) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      key_code <= fbd_pkg::FirstCode + 7'(low_idx);
      last_key <= ((key_mask & (key_mask - 1'b1)) == '0);
    end
  end

endmodule

FILE: sv/controller_frame_button_decoder_core.sv
// Path: a frame-closing byte passes the input register, the key mask and
// the output register before its first code shows. Throughput: one byte per
// cycle with no codes pending; one code per pressed button, at most 12.
// Reset: synchronous, active high; empties the window, the input register,
// the key mask and the output register.
// ----------------------------------------------------------------------------
// controller_frame_button_decoder_core: game controller frame decoder
// Slides an eight-byte window over received bytes, accepts frames that start
// with the sync byte and carry a valid seven-bit checksum, and sends one ASCII
// code per pressed button.
// ----------------------------------------------------------------------------
module controller_frame_button_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] key_code,
  output logic       last_key
);

  // Input register. A received byte waits here until the code sender can
  // take the button mask its frame might produce. With a byte held and only
  // the last code pending behind a valid output, the input stall follows the
  // output stall in the same cycle: that code leaving frees the key mask.
  logic       rx_held;
  logic [7:0] rx_byte_q;
  logic       consume;
  logic       in_take;

  fbd_pkg::frame_chk_t chk;
  fbd_pkg::emit_stat_t stat;

  // The held byte is processed once the key mask will be empty after this
  // cycle's send; the mask then reloads from the frame check (zero on a miss).
  assign consume  = rx_held && stat.free;
  assign in_stall = rx_held && !consume;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_held <= 1'b0;
    end else if (in_take) begin
      rx_held <= 1'b1;
    end else if (consume) begin
      rx_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rx_byte_q <= rx_byte;
    end
  end

  // Window and frame check: one short combinational pass over the held byte.
  fbd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .take    (consume),
    .rx_byte (rx_byte_q),
    .chk     (chk)
  );

  // Code sender with its own output register.
  fbd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (consume),
    .chk       (chk),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_code  (key_code),
    .last_key  (last_key)
  );

`ifndef NO_ASSERTIONS
  // A code that is not the last of its frame is followed at once by another.
  a_codes_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_key |=> out_valid)
    else $error("button codes of one frame were not sent back to back");

  // The input side only stalls while a byte is held.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> rx_held)
    else $error("input stalled with no byte held");

  // A new code only appears when the key mask had pending buttons.
  a_code_from_mask: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.busy))
    else $error("code sent without a pending button");
`endif

endmodule
